@@ rtl/psp_pkg.sv @@
// Package: constants, types and function codes for the polyphonic sample player.
package psp_pkg;

   localparam int VOICES       = 16;
   localparam int LAYERS       = 8;
   localparam int ROUND_ROBIN  = 8;
   localparam int SAMPLE_WORDS = 65536;

   localparam int VOICE_W = $clog2(VOICES);
   localparam int LAYER_W = $clog2(LAYERS);
   localparam int RR_W    = $clog2(ROUND_ROBIN);
   localparam int INST_W  = LAYER_W + RR_W;
   localparam int ADDR_W  = $clog2(SAMPLE_WORDS);

   localparam logic [16:0] FULL_VOLUME = 17'h10000;
   localparam logic [15:0] VEL_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      FUNC_NOTE   = 3'd0,
      FUNC_TICK   = 3'd1,
      FUNC_SAMPLE = 3'd2,
      FUNC_INST   = 3'd3,
      FUNC_COUNT  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      CSR_DECAY  = 2'd0,
      CSR_LAYERS = 2'd1,
      CSR_VOICES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] velocity;
      logic [2:0]  layer;
      logic [3:0]  slot;
      logic [15:0] address;
      logic [16:0] length;
      logic [15:0] sample_word;
   } req_type;

   typedef struct packed {
      logic [19:0] mixed_sample;
      logic        any_active;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

   // serial multiplier handshake
   typedef struct packed {
      logic        start;
      logic [16:0] a;
      logic [16:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [33:0] product;
   } mul_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PICK,
      ST_INST,
      ST_NOTE_DECAY,
      ST_NOTE_DONE,
      ST_VOICE,
      ST_READ,
      ST_MUL_VOL,
      ST_MUL_DEC,
      ST_NEXT,
      ST_ROUND,
      ST_OUT
   } state_type;

endpackage

@@ rtl/psp_if.sv @@
// Valid/ready channel interface with a generic payload type.
interface psp_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/psp_mul.sv @@
// Bit-serial 17x17 unsigned shift-add multiplier, one multiplier bit per cycle.
module psp_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  psp_pkg::mul_req_type mul_req,
   output psp_pkg::mul_rsp_type mul_rsp
);
   import psp_pkg::*;

   logic [33:0] acc_ff, acc_in;
   logic [33:0] mcand_ff, mcand_in;
   logic [16:0] mplier_ff, mplier_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (mul_req.start) begin
         acc_in    = '0;
         mcand_in  = {17'd0, mul_req.a};
         mplier_in = mul_req.b;
         count_in  = 5'd17;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[32:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[16:1]};
         count_in  = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("multiplier done held");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && count_ff != 5'd1 |=> busy_ff || mul_req.start)
      else $error("multiplier stopped early");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");
endmodule

@@ rtl/polyphonic_sample_player.sv @@
// Polyphonic sample player: velocity layers, round-robin instances, voice ring, mixer.
// One transaction at a time. Sample and table writes complete in the idle state. A note
// runs a 19-step restoring division, then the layer choice, the instance pick, the voice
// load, the 17-step serial decay multiply of the previous voice and a finishing step. In
// a tick, idle voices are skipped and each playing voice needs a sample memory read and
// two 17-step serial multiplies (sample by volume, volume by decay); the serial multiplier
// sets the rate. The result register lets the next transaction in while a result waits;
// a following tick holds in its rounding step until the waiting result is taken. No
// clearing pass after reset.
module polyphonic_sample_player (
   input  logic clock,
   input  logic reset,
   psp_if.sink   req,
   psp_if.source rsp,
   psp_if.sink   csr
);
   import psp_pkg::*;

   // configuration
   logic [15:0] decay_ff;
   logic [3:0]  layer_count_ff;
   logic [4:0]  voice_count_ff;

   // memories
   logic [15:0] sample_mem [SAMPLE_WORDS];
   logic [15:0] inst_start_mem [LAYERS*ROUND_ROBIN];
   logic [16:0] inst_len_mem [LAYERS*ROUND_ROBIN];
   logic [15:0] sample_rd_ff;
   logic [15:0] inst_start_rd_ff;
   logic [16:0] inst_len_rd_ff;

   // per-layer and per-voice state
   logic [3:0]  layer_inst_ff [LAYERS];
   logic [2:0]  layer_next_ff [LAYERS];
   logic [VOICE_W-1:0] next_voice_ff;
   logic [15:0] voice_start_ff [VOICES];
   logic [16:0] voice_len_ff [VOICES];
   logic [16:0] voice_pos_ff [VOICES];
   logic [16:0] voice_vol_ff [VOICES];
   logic [VOICES-1:0] voice_act_ff;

   state_type   state_ff, state_in;
   logic [3:0]  lc;
   logic [4:0]  ring;

   // division: velocity*lc (19 bits) / 65535
   logic [18:0] quo_ff;
   logic [16:0] rem_ff;
   logic [4:0]  div_cnt_ff;
   logic [2:0]  ly_ff;
   logic [2:0]  rr_ff;
   logic [VOICE_W-1:0] v_ff;
   logic [VOICE_W:0] j_ff;
   logic signed [39:0] acc_ff;
   logic        any_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   psp_mul u_mul (.clock(clock), .reset(reset), .mul_req(mreq), .mul_rsp(mrsp));

   assign lc   = (layer_count_ff > 4'(LAYERS)) ? 4'(LAYERS) : layer_count_ff;
   assign ring = (voice_count_ff == 5'd0) ? 5'd1
               : (voice_count_ff > 5'(VOICES)) ? 5'(VOICES) : voice_count_ff;

   assign csr.ready   = 1'b1;
   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   logic [VOICE_W-1:0] jv;
   logic [VOICE_W-1:0] prev_v;
   logic [16:0] rem_sh;
   logic [15:0] prod_sample;
   logic [3:0]  cnt;
   logic        plays;
   logic signed [40:0] sp;
   logic signed [40:0] q;

   assign jv     = j_ff[VOICE_W-1:0];
   assign prev_v = (v_ff == '0) ? VOICE_W'(ring - 5'd1) : v_ff - VOICE_W'(1);
   assign rem_sh = {rem_ff[15:0], quo_ff[18]};
   assign cnt    = layer_inst_ff[ly_ff];
   assign plays  = voice_act_ff[jv] && (voice_pos_ff[jv] < voice_len_ff[jv]);
   assign prod_sample = sample_rd_ff;
   // floor division by 65536 is an arithmetic shift
   assign q = 41'(acc_ff) >>> 16;

   always_comb begin
      state_in   = state_ff;
      mreq       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (req.payload.func)
                  FUNC_NOTE: begin
                     if (req.payload.velocity != 16'd0 && lc != 4'd0) state_in = ST_DIVIDE;
                  end
                  FUNC_TICK: state_in = ST_VOICE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIVIDE:     if (div_cnt_ff == 5'd0) state_in = ST_PICK;
         ST_PICK:       state_in = (cnt == 4'd0) ? ST_IDLE : ST_INST;
         ST_INST: begin
            state_in   = ST_NOTE_DECAY;
            mreq.start = 1'b1;
            mreq.a     = (prev_v == v_ff) ? FULL_VOLUME : voice_vol_ff[prev_v];
            mreq.b     = {1'b0, decay_ff};
         end
         ST_NOTE_DECAY: if (mrsp.done) state_in = ST_NOTE_DONE;
         ST_NOTE_DONE:  state_in = ST_IDLE;
         ST_VOICE: begin
            if (j_ff >= (VOICE_W+1)'(ring)) state_in = ST_ROUND;
            else if (plays) state_in = ST_READ;
            else state_in = ST_VOICE;
         end
         ST_READ: begin
            state_in   = ST_MUL_VOL;
            mreq.start = 1'b1;
            mreq.a     = voice_vol_ff[jv];
            mreq.b     = prod_sample[15] ? 17'(-{1'b1, prod_sample}) : {1'b0, prod_sample};
         end
         ST_MUL_VOL: begin
            if (mrsp.done) begin
               state_in   = ST_MUL_DEC;
               mreq.start = 1'b1;
               mreq.a     = voice_vol_ff[jv];
               mreq.b     = {1'b0, decay_ff};
            end
         end
         ST_MUL_DEC:    if (mrsp.done) state_in = ST_NEXT;
         ST_NEXT:       state_in = ST_VOICE;
         ST_ROUND:      if (!rsp_valid_ff || rsp.ready) state_in = ST_OUT;
         ST_OUT:        state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   assign sp = sample_rd_ff[15] ? -41'(mrsp.product) : 41'(mrsp.product);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         decay_ff       <= 16'hFFFF;
         layer_count_ff <= 4'd0;
         voice_count_ff <= 5'd16;
         next_voice_ff  <= '0;
         voice_act_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < LAYERS; i++) begin
            layer_inst_ff[i] <= '0;
            layer_next_ff[i] <= '0;
         end
         for (int i = 0; i < VOICES; i++) begin
            voice_start_ff[i] <= '0;
            voice_len_ff[i]   <= '0;
            voice_pos_ff[i]   <= '0;
            voice_vol_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            case (csr.payload.index)
               CSR_DECAY:  decay_ff       <= csr.payload.data;
               CSR_LAYERS: layer_count_ff <= csr.payload.data[3:0];
               CSR_VOICES: voice_count_ff <= csr.payload.data[4:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  quo_ff     <= 19'(req.payload.velocity) * 19'(lc);
                  rem_ff     <= '0;
                  div_cnt_ff <= 5'd19;
                  j_ff       <= '0;
                  acc_ff     <= '0;
                  any_ff     <= 1'b0;
                  case (req.payload.func)
                     FUNC_INST: begin
                        if (req.payload.slot < 4'(ROUND_ROBIN)) begin
                           inst_start_mem[{req.payload.layer, req.payload.slot[RR_W-1:0]}]
                              <= req.payload.address;
                           inst_len_mem[{req.payload.layer, req.payload.slot[RR_W-1:0]}]
                              <= req.payload.length;
                        end
                     end
                     FUNC_COUNT: begin
                        layer_inst_ff[req.payload.layer] <=
                           (req.payload.slot > 4'(ROUND_ROBIN)) ? 4'(ROUND_ROBIN)
                                                                : req.payload.slot;
                     end
                     default: ;
                  endcase
               end
            end
            ST_DIVIDE: begin
               if (div_cnt_ff != 5'd0) begin
                  div_cnt_ff <= div_cnt_ff - 5'd1;
                  if (rem_sh >= 17'(VEL_MAX)) begin
                     rem_ff <= rem_sh - 17'(VEL_MAX);
                     quo_ff <= {quo_ff[17:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[17:0], 1'b0};
                  end
               end else begin
                  ly_ff <= (quo_ff >= 19'(lc)) ? 3'(lc - 4'd1) : quo_ff[2:0];
               end
            end
            ST_PICK: begin
               rr_ff <= (4'(layer_next_ff[ly_ff]) >= cnt) ? 3'd0 : layer_next_ff[ly_ff];
               v_ff  <= (5'(next_voice_ff) < ring) ? next_voice_ff : '0;
               inst_start_rd_ff <= inst_start_mem[{ly_ff,
                  (4'(layer_next_ff[ly_ff]) >= cnt) ? 3'd0 : layer_next_ff[ly_ff]}];
               inst_len_rd_ff   <= inst_len_mem[{ly_ff,
                  (4'(layer_next_ff[ly_ff]) >= cnt) ? 3'd0 : layer_next_ff[ly_ff]}];
            end
            ST_INST: begin
               voice_start_ff[v_ff] <= inst_start_rd_ff;
               voice_len_ff[v_ff]   <= inst_len_rd_ff;
               voice_pos_ff[v_ff]   <= '0;
               voice_vol_ff[v_ff]   <= FULL_VOLUME;
               voice_act_ff[v_ff]   <= 1'b1;
               next_voice_ff <= (5'(v_ff) + 5'd1 >= ring) ? '0 : v_ff + VOICE_W'(1);
               layer_next_ff[ly_ff] <= (4'(rr_ff) + 4'd1 >= cnt) ? 3'd0 : rr_ff + 3'd1;
            end
            ST_NOTE_DECAY: begin
               if (mrsp.done) voice_vol_ff[prev_v] <= mrsp.product[32:16];
            end
            ST_VOICE: begin
               if (j_ff < (VOICE_W+1)'(ring)) begin
                  if (plays) begin
                     any_ff <= 1'b1;
                     sample_rd_ff <= sample_mem[16'(voice_start_ff[jv] + voice_pos_ff[jv])];
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            ST_MUL_VOL: begin
               if (mrsp.done) acc_ff <= acc_ff + 40'(sp);
            end
            ST_MUL_DEC: begin
               if (mrsp.done && voice_vol_ff[jv] < FULL_VOLUME)
                  voice_vol_ff[jv] <= mrsp.product[32:16];
            end
            ST_NEXT: begin
               voice_pos_ff[jv] <= voice_pos_ff[jv] + 17'd1;
               j_ff <= j_ff + 1'b1;
            end
            ST_ROUND: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.any_active <= any_ff;
                  if (q > 41'sd524287)       rsp_ff.mixed_sample <= 20'h7FFFF;
                  else if (q < -41'sd524288) rsp_ff.mixed_sample <= 20'h80000;
                  else                       rsp_ff.mixed_sample <= q[19:0];
               end
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
         if (state_ff == ST_IDLE && req.valid && req.ready &&
             req.payload.func == FUNC_SAMPLE)
            sample_mem[req.payload.address] <= req.payload.sample_word;
      end
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready while busy");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid_ff) else $error("result lost");
   a_voice_in_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> 5'(jv) < ring) else $error("voice outside ring");
endmodule

@@ tb/polyphonic_sample_player_tb.sv @@
// Testbench for the polyphonic sample player: directed table, then random phases checked by a predictor.
module polyphonic_sample_player_tb;
   import psp_pkg::*;

   localparam int          LIMIT            = 4000000;
   localparam int          SETTLE           = 200;
   localparam int          ITEMS_PER_PHASE  = 180;
   localparam int          NPHASE           = 6;
   localparam logic [2:0]  FUNC_FIRST_SPARE = 3'd5;
   localparam logic [2:0]  FUNC_LAST_SPARE  = 3'd7;

   typedef struct {
      req_type    item;
      bit         typed;
      rsp_type    result;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   psp_if #(.payload_type(req_type)) req_ch (clock);
   psp_if #(.payload_type(rsp_type)) rsp_ch (clock);
   psp_if #(.payload_type(csr_type)) csr_ch (clock);

   polyphonic_sample_player u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the block
   logic [15:0] p_decay;
   logic [3:0]  p_layers;
   logic [4:0]  p_voices;
   logic [15:0] smem      [SAMPLE_WORDS];
   bit          s_written [SAMPLE_WORDS];
   logic [15:0] inst_addr [LAYERS*ROUND_ROBIN];
   logic [16:0] inst_len  [LAYERS*ROUND_ROBIN];
   bit          i_written [LAYERS*ROUND_ROBIN];
   int unsigned layer_cnt [LAYERS];
   int unsigned layer_rr  [LAYERS];
   int unsigned next_v;
   int unsigned v_start   [VOICES];
   int unsigned v_len     [VOICES];
   int unsigned v_pos     [VOICES];
   int unsigned v_vol     [VOICES];
   bit          v_on      [VOICES];

   rsp_type     mix_queue [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          n_items = 0, n_notes = 0, n_ticks = 0, n_mixes = 0;
   bit          idle_on = 1'b1;
   dir_row_type dir_rows [19];

   logic [15:0] ph_decay  [NPHASE] = '{16'd65535, 16'd0, 16'd32768, 16'd1, 16'd50000, 16'd65535};
   logic [15:0] ph_layers [NPHASE] = '{16'd8, 16'd1, 16'd3, 16'd15, 16'd0, 16'd5};
   logic [15:0] ph_voices [NPHASE] = '{16'd16, 16'd1, 16'd5, 16'd0, 16'd31, 16'd16};

   function automatic int unsigned ring();
      if (p_voices == 0) return 1;
      if (p_voices > VOICES) return VOICES;
      return p_voices;
   endfunction

   function automatic int unsigned decayed(input int unsigned v);
      return int'((longint'(v) * longint'(p_decay)) >>> 16);
   endfunction

   function automatic int note_slot(input logic [15:0] vel);
      int unsigned lc, ly, rr;
      lc = (p_layers > LAYERS) ? LAYERS : p_layers;
      if (vel == 0 || lc == 0) return -1;
      ly = int'((longint'(vel) * lc) / 65535);
      if (ly >= lc) ly = lc - 1;
      if (layer_cnt[ly] == 0) return -1;
      rr = layer_rr[ly];
      if (rr >= layer_cnt[ly]) rr = 0;
      return ly * ROUND_ROBIN + rr;
   endfunction

   function automatic int unsigned read_addr(input int j);
      return (v_start[j] + v_pos[j]) % SAMPLE_WORDS;
   endfunction

   task automatic predict(input req_type r, output bit has_mix, output rsp_type m);
      int          idx, ly, v, p, n;
      longint      acc;
      longint      q;
      bit          any;
      has_mix = 1'b0;
      m = '0;
      case (r.func)
         FUNC_NOTE: begin
            idx = note_slot(r.velocity);
            if (idx >= 0) begin
               ly = idx / ROUND_ROBIN;
               n = ring();
               v = (next_v < n) ? next_v : 0;
               v_start[v] = inst_addr[idx];
               v_len[v] = inst_len[idx];
               v_pos[v] = 0;
               v_vol[v] = FULL_VOLUME;
               v_on[v] = 1'b1;
               p = (v + n - 1) % n;
               v_vol[p] = decayed(v_vol[p]);
               next_v = (v + 1) % n;
               layer_rr[ly] = (idx % ROUND_ROBIN + 1) % layer_cnt[ly];
            end
         end
         FUNC_TICK: begin
            acc = 0;
            any = 1'b0;
            for (int j = 0; j < ring(); j++) begin
               if (v_on[j] && v_pos[j] < v_len[j]) begin
                  any = 1'b1;
                  acc += longint'(v_vol[j]) * longint'($signed(smem[read_addr(j)]));
                  v_pos[j]++;
                  if (v_vol[j] < FULL_VOLUME) v_vol[j] = decayed(v_vol[j]);
               end
            end
            q = acc >>> 16;
            if (q > 524287) q = 524287;
            if (q < -524288) q = -524288;
            m.mixed_sample = q[19:0];
            m.any_active = any;
            has_mix = 1'b1;
         end
         FUNC_SAMPLE: begin
            smem[r.address] = r.sample_word;
            s_written[r.address] = 1'b1;
         end
         FUNC_INST: begin
            if (r.slot < ROUND_ROBIN) begin
               idx = r.layer * ROUND_ROBIN + r.slot;
               inst_addr[idx] = r.address;
               inst_len[idx] = r.length;
               i_written[idx] = 1'b1;
            end
         end
         FUNC_COUNT: layer_cnt[r.layer] = (r.slot > ROUND_ROBIN) ? ROUND_ROBIN : r.slot;
         default: ;
      endcase
   endtask

   task automatic drive_item(input req_type r, input bit typed, input rsp_type typed_mix);
      bit      has_mix;
      rsp_type m;
      if (idle_on && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      predict(r, has_mix, m);
      if (has_mix) mix_queue.push_back(typed ? typed_mix : m);
      n_items++;
      if (r.func == FUNC_NOTE) n_notes++;
      if (r.func == FUNC_TICK) n_ticks++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      csr_type c;
      c.index = idx;
      c.data = data;
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= c;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_DECAY:  p_decay = data;
         CSR_LAYERS: p_layers = data[3:0];
         CSR_VOICES: p_voices = data[4:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (mix_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type random_item();
      req_type r;
      r.func = FUNC_NOTE;
      r.velocity = 16'($urandom_range(0, 65535));
      r.layer = 3'($urandom_range(0, 7));
      r.slot = 4'($urandom_range(0, 8));
      r.address = 16'($urandom_range(0, 65535));
      r.length = 17'($urandom_range(0, 65536));
      r.sample_word = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic send(input req_type r);
      drive_item(r, 1'b0, '0);
   endtask

   task automatic random_step();
      req_type r, fix;
      int      k, idx;
      r = random_item();
      k = $urandom_range(99);
      if (k < 30) begin
         r.func = FUNC_NOTE;
         case ($urandom_range(9))
            0: r.velocity = '0;
            1: r.velocity = VEL_MAX;
            2: r.velocity = 16'd1;
            default: ;
         endcase
         idx = note_slot(r.velocity);
         if (idx >= 0 && !i_written[idx]) begin
            fix = random_item();
            fix.func = FUNC_INST;
            fix.layer = 3'(idx / ROUND_ROBIN);
            fix.slot = 4'(idx % ROUND_ROBIN);
            fix.address = 16'($urandom_range(0, 63));
            fix.length = 17'($urandom_range(0, 24));
            send(fix);
         end
      end else if (k < 65) begin
         r.func = FUNC_TICK;
         for (int j = 0; j < ring(); j++) begin
            if (v_on[j] && v_pos[j] < v_len[j] && !s_written[read_addr(j)]) begin
               fix = random_item();
               fix.func = FUNC_SAMPLE;
               fix.address = 16'(read_addr(j));
               send(fix);
            end
         end
      end else if (k < 80) begin
         r.func = FUNC_SAMPLE;
         if ($urandom_range(1)) r.address = 16'($urandom_range(0, 63));
      end else if (k < 90) begin
         r.func = FUNC_INST;
         if ($urandom_range(99) < 80) r.address = 16'($urandom_range(0, 63));
         case ($urandom_range(19))
            0:  r.length = 17'd65536;
            1, 2: ;
            default: r.length = 17'($urandom_range(0, 24));
         endcase
      end else if (k < 97) begin
         r.func = FUNC_COUNT;
         if ($urandom_range(9) == 0) r.slot = 4'($urandom_range(9, 15));
      end else begin
         r.func = 3'($urandom_range(FUNC_FIRST_SPARE, FUNC_LAST_SPARE));
      end
      send(r);
   endtask

   function automatic dir_row_type row(input logic [2:0] func, input logic [15:0] vel,
                                       input logic [2:0] ly, input logic [3:0] slot,
                                       input logic [15:0] addr, input logic [16:0] len,
                                       input logic [15:0] word, input bit typed,
                                       input logic [19:0] mix, input bit any);
      dir_row_type d;
      d.item = '{func, vel, ly, slot, addr, len, word};
      d.typed = typed;
      d.result = '{mix, any};
      return d;
   endfunction

   // result checking
   always @(posedge clock) begin
      rsp_type exp_mix;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_mixes++;
         if (mix_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %h", rsp_ch.payload);
         end else begin
            exp_mix = mix_queue.pop_front();
            if (rsp_ch.payload.mixed_sample !== exp_mix.mixed_sample ||
                rsp_ch.payload.any_active !== exp_mix.any_active) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: mix exp %h got %h, active exp %b got %b",
                           exp_mix.mixed_sample, rsp_ch.payload.mixed_sample,
                           exp_mix.any_active, rsp_ch.payload.any_active);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= idle_on ? ($urandom_range(99) >= 14) : 1'b1;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.payload <= '0;
      p_decay = 16'd65535;
      p_layers = '0;
      p_voices = 5'd16;
      next_v = 0;
      foreach (layer_cnt[i]) begin
         layer_cnt[i] = 0;
         layer_rr[i] = 0;
      end
      foreach (v_on[j]) begin
         v_start[j] = 0; v_len[j] = 0; v_pos[j] = 0; v_vol[j] = 0; v_on[j] = 1'b0;
      end
      dir_rows[0]  = row(FUNC_TICK,   16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b1, 20'h00000, 1'b0);
      dir_rows[1]  = row(FUNC_NOTE,   VEL_MAX,   3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[2]  = row(FUNC_SAMPLE, 16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'h7FFF,
                         1'b0, '0, 1'b0);
      dir_rows[3]  = row(FUNC_SAMPLE, 16'd0,     3'd0, 4'd0,  16'hFFFF,  17'd0,     16'h8000,
                         1'b0, '0, 1'b0);
      dir_rows[4]  = row(FUNC_SAMPLE, 16'd0,     3'd0, 4'd0,  16'd1,     17'd0,     16'h0000,
                         1'b0, '0, 1'b0);
      dir_rows[5]  = row(FUNC_INST,   16'd0,     3'd1, 4'd0,  16'd0,     17'd2,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[6]  = row(FUNC_INST,   16'd0,     3'd0, 4'd0,  16'hFFFF,  17'd1,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[7]  = row(FUNC_INST,   16'd0,     3'd7, 4'd8,  16'd0,     17'd65536, 16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[8]  = row(FUNC_COUNT,  16'd0,     3'd1, 4'd15, 16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[9]  = row(FUNC_COUNT,  16'd0,     3'd1, 4'd1,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[10] = row(FUNC_COUNT,  16'd0,     3'd0, 4'd1,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[11] = row(FUNC_NOTE,   VEL_MAX,   3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[12] = row(FUNC_TICK,   16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b1, 20'h07FFF, 1'b1);
      dir_rows[13] = row(FUNC_NOTE,   16'd1,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[14] = row(FUNC_TICK,   16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b1, 20'hF8000, 1'b1);
      dir_rows[15] = row(FUNC_TICK,   16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b1, 20'h00000, 1'b0);
      dir_rows[16] = row(FUNC_FIRST_SPARE, 16'd0, 3'd0, 4'd0, 16'd0,    17'd0,     16'd0,
                         1'b0, '0, 1'b0);
      dir_rows[17] = row(FUNC_LAST_SPARE, VEL_MAX, 3'd7, 4'd15, 16'hFFFF, 17'h1FFFF, 16'hFFFF,
                         1'b0, '0, 1'b0);
      dir_rows[18] = row(FUNC_NOTE,   16'd0,     3'd0, 4'd0,  16'd0,     17'd0,     16'd0,
                         1'b0, '0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first tick sees the reset state, then a two-layer, four-voice set-up
      drive_item(dir_rows[0].item, dir_rows[0].typed, dir_rows[0].result);
      drain();
      write_reg(CSR_DECAY, 16'd32768);
      write_reg(CSR_LAYERS, 16'd2);
      write_reg(CSR_VOICES, 16'd4);
      for (int i = 1; i < $size(dir_rows); i++)
         drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
      drain();

      for (int ph = 0; ph < NPHASE; ph++) begin
         write_reg(CSR_DECAY, ph_decay[ph]);
         write_reg(CSR_LAYERS, ph_layers[ph]);
         write_reg(CSR_VOICES, ph_voices[ph]);
         idle_on = (ph != 2);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) random_step();
         drain();
      end

      $display("covered %0d transactions (%0d notes, %0d ticks), %0d mixes checked",
               n_items, n_notes, n_ticks, n_mixes);
      $display("%0d register settings incl. out-of-range counts, %0d mismatches",
               NPHASE + 1, mismatches);
      if (mismatches == 0 && mix_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
